### sv/slbs_pkg.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer package
// Shared types and constants: tick and status beats, pattern phases and
// configuration register indexes.
// ----------------------------------------------------------------------------
package slbs_pkg;

    localparam int TIME_W  = 16;
    localparam int TICKS_W = 17;
    localparam int CFG_INDEX_W = 3;

    localparam logic [TICKS_W-1:0] TICK_MAX = '1;

    localparam logic [TIME_W-1:0] PULSE_ON_RESET      = 16'd150;
    localparam logic [TIME_W-1:0] PULSE_GAP_RESET     = 16'd120;
    localparam logic [TIME_W-1:0] GROUP_PAUSE_RESET   = 16'd300;
    localparam logic [TIME_W-1:0] LONG_PAUSE_RESET    = 16'd1000;
    localparam logic [TIME_W-1:0] FAULT_HALF_RESET    = 16'd150;

    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_ON_TIME     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_GAP_TIME    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_PAUSE_TIME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PAUSE_TIME   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_HALF_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_DISABLED  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_OVERRIDE   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_LEVEL      = 3'd7;

    typedef enum logic [3:0] {
        PH_NET_ON      = 4'd0,
        PH_NET_GAP     = 4'd1,
        PH_NET_SECOND  = 4'd2,
        PH_NET_PAUSE   = 4'd3,
        PH_GNSS_ON     = 4'd4,
        PH_GNSS_GAP    = 4'd5,
        PH_GNSS_SECOND = 4'd6,
        PH_GNSS_PAUSE  = 4'd7,
        PH_LONG_PAUSE  = 4'd8
    } phase_t;

    typedef struct packed {
        logic modem_powered;
        logic init_attempted;
        logic uart_responding;
        logic modem_ready;
        logic net_registered;
        logic gnss_enabled;
        logic gnss_fix;
    } tick_t;

    typedef struct packed {
        logic       led_level;
        logic       drive_enable;
        logic [3:0] pattern_phase;
        logic       fault_mode;
    } status_t;

endpackage

### sv/status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer
// Takes one tick beat per millisecond with modem and GNSS status bits and
// produces one status beat per tick with the LED level and pattern phase.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ------------------------------------
//  tick     tick_valid / tick_stall  tick   (status bits, in)
//  status   status_valid / stall     status (LED level, phase, fault, out)
//  cfg      cfg_valid / cfg_ready    cfg_index, cfg_data (register write)
//
//  A new tick can be accepted every cycle while tick_stall is low.
//  The pattern state and the status register update together at acceptance.
//  The status register holds one beat; tick_stall is high only while that
//  beat is waiting and status_stall is high.
//  Reset puts the configuration and pattern registers to their reset values
//  and empties the status register; the status payload itself is not reset.
//
module status_led_blink_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  slbs_pkg::tick_t                  tick,
    output logic                             status_valid,
    input  logic                             status_stall,
    output slbs_pkg::status_t                status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slbs_pkg::TIME_W-1:0]      cfg_data
);
    import slbs_pkg::*;

    logic [TIME_W-1:0]  pulse_on_reg;
    logic [TIME_W-1:0]  pulse_gap_reg;
    logic [TIME_W-1:0]  group_pause_reg;
    logic [TIME_W-1:0]  rest_time_reg;
    logic [TIME_W-1:0]  fault_half_reg;
    logic               disabled_reg;
    logic               override_reg;
    logic               manual_level_reg;

    phase_t             phase_reg, phase_next;
    logic [TICKS_W-1:0] phase_ticks_reg, phase_ticks_next;
    logic [TICKS_W-1:0] fault_ticks_reg, fault_ticks_next;
    logic               fault_level_reg, fault_level_next;
    logic               led_reg, led_next;

    logic               status_valid_reg;
    status_t            status_reg, status_next;

    logic               accept;
    logic               faulted;
    logic               net_ok;
    logic               gnss_ok;
    logic               group_ok;
    logic [TICKS_W-1:0] phase_ticks_inc;
    logic [TICKS_W-1:0] fault_ticks_inc;
    logic [TICKS_W-1:0] second_len;
    logic               pat_advance;
    phase_t             pat_phase;
    logic               pat_led;

    assign cfg_ready    = 1'b1;
    assign tick_stall   = status_valid_reg && status_stall;
    assign accept       = tick_valid && !tick_stall;
    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    assign faulted = !tick.modem_powered || (tick.init_attempted && !tick.uart_responding);
    assign net_ok  = tick.modem_ready && tick.net_registered;
    assign gnss_ok = tick.gnss_enabled && tick.gnss_fix;

    assign phase_ticks_inc = (phase_ticks_reg == TICK_MAX) ? TICK_MAX : phase_ticks_reg + 1'b1;
    assign fault_ticks_inc = (fault_ticks_reg == TICK_MAX) ? TICK_MAX : fault_ticks_reg + 1'b1;
    assign second_len      = {1'b0, pulse_gap_reg} + {1'b0, pulse_on_reg};

    always_comb
    begin
        pat_phase   = phase_reg;
        pat_led     = led_reg;
        pat_advance = 1'b0;
        group_ok    = (phase_reg == PH_NET_ON) ? net_ok : gnss_ok;
        unique case (phase_reg)
            PH_NET_ON, PH_GNSS_ON:
            begin
                pat_led = 1'b1;
                if (phase_ticks_inc >= {1'b0, pulse_on_reg})
                begin
                    pat_led     = 1'b0;
                    pat_advance = 1'b1;
                    pat_phase   = group_ok ? phase_t'(phase_reg + 4'd3)
                                           : phase_t'(phase_reg + 4'd1);
                end
            end
            PH_NET_GAP, PH_GNSS_GAP:
            begin
                if (phase_ticks_inc >= {1'b0, pulse_gap_reg})
                begin
                    pat_advance = 1'b1;
                    pat_phase   = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_NET_SECOND, PH_GNSS_SECOND:
            begin
                pat_led = 1'b1;
                if (phase_ticks_inc >= second_len)
                begin
                    pat_led     = 1'b0;
                    pat_advance = 1'b1;
                    pat_phase   = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_NET_PAUSE, PH_GNSS_PAUSE:
            begin
                if (phase_ticks_inc >= {1'b0, group_pause_reg})
                begin
                    pat_advance = 1'b1;
                    pat_phase   = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_LONG_PAUSE:
            begin
                if (phase_ticks_inc >= {1'b0, rest_time_reg})
                begin
                    pat_advance = 1'b1;
                    pat_phase   = PH_NET_ON;
                end
            end
            default:
            begin
                pat_advance = 1'b1;
                pat_phase   = PH_NET_ON;
            end
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_inc;
        fault_ticks_next = fault_ticks_inc;
        fault_level_next = fault_level_reg;
        led_next         = led_reg;
        status_next      = '0;
        if (disabled_reg)
        begin
            status_next.drive_enable = 1'b0;
            status_next.led_level    = 1'b0;
        end
        else if (override_reg)
        begin
            led_next                 = manual_level_reg;
            status_next.drive_enable = 1'b1;
            status_next.led_level    = manual_level_reg;
        end
        else if (faulted)
        begin
            if (fault_ticks_inc >= {1'b0, fault_half_reg})
            begin
                fault_level_next = !fault_level_reg;
                led_next         = !fault_level_reg;
                fault_ticks_next = '0;
            end
            status_next.drive_enable = 1'b1;
            status_next.fault_mode   = 1'b1;
            status_next.led_level    = led_next;
        end
        else
        begin
            phase_next = pat_phase;
            led_next   = pat_led;
            if (pat_advance)
            begin
                phase_ticks_next = '0;
            end
            status_next.drive_enable = 1'b1;
            status_next.led_level    = pat_led;
        end
        status_next.pattern_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_on_reg     <= PULSE_ON_RESET;
            pulse_gap_reg    <= PULSE_GAP_RESET;
            group_pause_reg  <= GROUP_PAUSE_RESET;
            rest_time_reg    <= LONG_PAUSE_RESET;
            fault_half_reg   <= FAULT_HALF_RESET;
            disabled_reg     <= 1'b0;
            override_reg     <= 1'b0;
            manual_level_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PULSE_ON_TIME:     pulse_on_reg     <= cfg_data;
                CFG_PULSE_GAP_TIME:    pulse_gap_reg    <= cfg_data;
                CFG_GROUP_PAUSE_TIME:  group_pause_reg  <= cfg_data;
                CFG_LONG_PAUSE_TIME:   rest_time_reg    <= cfg_data;
                CFG_FAULT_HALF_PERIOD: fault_half_reg   <= cfg_data;
                CFG_PATTERN_DISABLED:  disabled_reg     <= cfg_data[0];
                CFG_MANUAL_OVERRIDE:   override_reg     <= cfg_data[0];
                CFG_MANUAL_LEVEL:      manual_level_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_NET_ON;
            phase_ticks_reg  <= '0;
            fault_ticks_reg  <= '0;
            fault_level_reg  <= 1'b0;
            led_reg          <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                phase_ticks_reg  <= phase_ticks_next;
                fault_ticks_reg  <= fault_ticks_next;
                fault_level_reg  <= fault_level_next;
                led_reg          <= led_next;
                status_valid_reg <= 1'b1;
            end
            else if (!status_stall)
            begin
                status_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    a_fault_drives: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> (!status.fault_mode || status.drive_enable))
        else $error("Fault beat without pin drive.");

    a_released_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid && !status.drive_enable) |-> !status.led_level)
        else $error("Released pin reported lit.");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> (status.pattern_phase <= 4'd8))
        else $error("Pattern phase out of range.");

    a_fault_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (disabled_reg || override_reg || faulted)) |=>
            (phase_reg == $past(phase_reg)))
        else $error("Phase moved outside the pattern mode.");

    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> status_valid_reg)
        else $error("Tick stalled with empty status register.");

endmodule

### bench/tb_status_led_blink_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED blink sequencer testbench
// Drives tick beats through the sequencer under random sender gaps and
// receiver stalls, and predicts every status beat from a copy of the blink
// pattern, fault blinking, override and disable logic. The run covers zero
// and full-scale durations and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_status_led_blink_sequencer;

    import slbs_pkg::*;

    class led_status_scoreboard;
        status_t                expected_status_q[$];
        int                     mismatches;
        logic [TIME_W-1:0]      pulse_on;
        logic [TIME_W-1:0]      pulse_gap;
        logic [TIME_W-1:0]      group_pause;
        logic [TIME_W-1:0]      rest_time;
        logic [TIME_W-1:0]      half_period;
        logic                   disabled;
        logic                   override;
        logic                   manual_lvl;
        phase_t                 phase;
        logic [TICKS_W-1:0]     phase_ticks;
        logic [TICKS_W-1:0]     fault_ticks;
        logic                   fault_lvl;
        logic                   led;

        function new();
            mismatches  = 0;
            pulse_on    = PULSE_ON_RESET;
            pulse_gap   = PULSE_GAP_RESET;
            group_pause = GROUP_PAUSE_RESET;
            rest_time   = LONG_PAUSE_RESET;
            half_period = FAULT_HALF_RESET;
            disabled    = 1'b0;
            override    = 1'b0;
            manual_lvl  = 1'b0;
            phase       = PH_NET_ON;
            phase_ticks = '0;
            fault_ticks = '0;
            fault_lvl   = 1'b0;
            led         = 1'b0;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [TIME_W-1:0] data);
            case (idx)
                CFG_PULSE_ON_TIME:     pulse_on    = data;
                CFG_PULSE_GAP_TIME:    pulse_gap   = data;
                CFG_GROUP_PAUSE_TIME:  group_pause = data;
                CFG_LONG_PAUSE_TIME:   rest_time   = data;
                CFG_FAULT_HALF_PERIOD: half_period = data;
                CFG_PATTERN_DISABLED:  disabled    = data[0];
                CFG_MANUAL_OVERRIDE:   override    = data[0];
                CFG_MANUAL_LEVEL:      manual_lvl  = data[0];
                default: ;
            endcase
        endfunction

        function void enter_phase(phase_t p);
            phase       = p;
            phase_ticks = '0;
        endfunction

        function void note_tick(tick_t t);
            status_t            want;
            logic [TICKS_W-1:0] second_len;
            logic               grp_ok;
            want       = '0;
            second_len = {1'b0, pulse_gap} + {1'b0, pulse_on};
            if (phase_ticks != TICK_MAX)
                phase_ticks++;
            if (fault_ticks != TICK_MAX)
                fault_ticks++;
            if (!disabled)
            begin
                want.drive_enable = 1'b1;
                if (override)
                    led = manual_lvl;
                else if (!t.modem_powered || (t.init_attempted && !t.uart_responding))
                begin
                    want.fault_mode = 1'b1;
                    if (fault_ticks >= half_period)
                    begin
                        fault_lvl   = ~fault_lvl;
                        led         = fault_lvl;
                        fault_ticks = '0;
                    end
                end
                else
                begin
                    case (phase)
                        PH_NET_ON, PH_GNSS_ON:
                        begin
                            grp_ok = (phase == PH_NET_ON) ?
                                     (t.modem_ready & t.net_registered) :
                                     (t.gnss_enabled & t.gnss_fix);
                            led = 1'b1;
                            if (phase_ticks >= pulse_on)
                            begin
                                led = 1'b0;
                                enter_phase(phase_t'(phase + (grp_ok ? 4'd3 : 4'd1)));
                            end
                        end
                        PH_NET_GAP, PH_GNSS_GAP:
                            if (phase_ticks >= pulse_gap)
                                enter_phase(phase_t'(phase + 4'd1));
                        PH_NET_SECOND, PH_GNSS_SECOND:
                        begin
                            led = 1'b1;
                            if (phase_ticks >= second_len)
                            begin
                                led = 1'b0;
                                enter_phase(phase_t'(phase + 4'd1));
                            end
                        end
                        PH_NET_PAUSE, PH_GNSS_PAUSE:
                            if (phase_ticks >= group_pause)
                                enter_phase(phase_t'(phase + 4'd1));
                        PH_LONG_PAUSE:
                            if (phase_ticks >= rest_time)
                                enter_phase(PH_NET_ON);
                        default:
                            enter_phase(PH_NET_ON);
                    endcase
                end
                want.led_level = led;
            end
            want.pattern_phase = phase;
            expected_status_q.push_back(want);
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (expected_status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status beat: led=%0b drive=%0b phase=%0d fault=%0b",
                             got.led_level, got.drive_enable, got.pattern_phase,
                             got.fault_mode);
                return;
            end
            want = expected_status_q.pop_front();
            if (got.led_level !== want.led_level || got.drive_enable !== want.drive_enable ||
                got.pattern_phase !== want.pattern_phase || got.fault_mode !== want.fault_mode)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("status mismatch: expected led=%0b drive=%0b phase=%0d fault=%0b",
                             want.led_level, want.drive_enable, want.pattern_phase,
                             want.fault_mode);
                    $display("                 got      led=%0b drive=%0b phase=%0d fault=%0b",
                             got.led_level, got.drive_enable, got.pattern_phase,
                             got.fault_mode);
                end
            end
        endfunction
    endclass

    typedef struct {
        logic [TIME_W-1:0] pulse_on;
        logic [TIME_W-1:0] pulse_gap;
        logic [TIME_W-1:0] group_pause;
        logic [TIME_W-1:0] rest_time;
        logic [TIME_W-1:0] half_period;
        logic              disabled;
        logic              override;
        logic              level;
    } led_settings_t;

    localparam tick_t TK_ALL_OK   = '1;
    localparam tick_t TK_UNPOWERED = '0;
    localparam tick_t TK_NET_DOWN = '{modem_powered: 1'b1, init_attempted: 1'b1,
                                      uart_responding: 1'b1, default: 1'b0};
    localparam tick_t TK_SILENT   = '{modem_powered: 1'b1, init_attempted: 1'b1,
                                      uart_responding: 1'b0, default: 1'b1};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   tick_valid;
    logic                   tick_stall;
    tick_t                  tick;
    logic                   status_valid;
    logic                   status_stall;
    status_t                status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TIME_W-1:0]      cfg_data;

    bit idle_on    = 1'b0;
    bit hold_armed = 1'b0;

    led_status_scoreboard board = new();

    status_led_blink_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.note_config(cfg_index, cfg_data);
            if (tick_valid && !tick_stall)
                board.note_tick(tick);
            if (status_valid && !status_stall)
                board.check_status(status);
        end
    end

    function automatic int idle_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 80)
            return TIME_W'($urandom_range(1, 6));
        if (r < 95)
            return TIME_W'($urandom_range(7, 40));
        return TIME_W'(16'hFFFF - $urandom_range(0, 3));
    endfunction

    function automatic led_settings_t uniform_settings(logic [TIME_W-1:0] d);
        led_settings_t s;
        s.pulse_on    = d;
        s.pulse_gap   = d;
        s.group_pause = d;
        s.rest_time   = d;
        s.half_period = d;
        s.disabled    = 1'b0;
        s.override    = 1'b0;
        s.level       = 1'b0;
        return s;
    endfunction

    function automatic tick_t make_tick(int fault_pct);
        tick_t t;
        t.modem_ready    = ($urandom_range(0, 3) != 0);
        t.net_registered = ($urandom_range(0, 3) != 0);
        t.gnss_enabled   = ($urandom_range(0, 3) != 0);
        t.gnss_fix       = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < fault_pct)
        begin
            if ($urandom_range(0, 1))
            begin
                t.modem_powered   = 1'b0;
                t.init_attempted  = 1'($urandom_range(0, 1));
                t.uart_responding = 1'($urandom_range(0, 1));
            end
            else
            begin
                t.modem_powered   = 1'b1;
                t.init_attempted  = 1'b1;
                t.uart_responding = 1'b0;
            end
        end
        else
        begin
            t.modem_powered   = 1'b1;
            t.init_attempted  = 1'($urandom_range(0, 1));
            t.uart_responding = t.init_attempted ? 1'b1 : 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do @(posedge clk); while (tick_stall);
    endtask

    task automatic send_ticks(input tick_t t, input int count);
        for (int k = 0; k < count; k++)
            send_tick(t);
        tick_valid <= 1'b0;
    endtask

    task automatic send_burst(input int count, input int fault_pct);
        for (int k = 0; k < count; k++)
            send_tick(make_tick(fault_pct));
        tick_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input led_settings_t s);
        logic [TIME_W-2:0] junk;
        write_reg(CFG_PULSE_ON_TIME, s.pulse_on);
        write_reg(CFG_PULSE_GAP_TIME, s.pulse_gap);
        write_reg(CFG_GROUP_PAUSE_TIME, s.group_pause);
        write_reg(CFG_LONG_PAUSE_TIME, s.rest_time);
        write_reg(CFG_FAULT_HALF_PERIOD, s.half_period);
        junk = (TIME_W-1)'($urandom);
        write_reg(CFG_PATTERN_DISABLED, {junk, s.disabled});
        junk = (TIME_W-1)'($urandom);
        write_reg(CFG_MANUAL_OVERRIDE, {junk, s.override});
        junk = (TIME_W-1)'($urandom);
        write_reg(CFG_MANUAL_LEVEL, {junk, s.level});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (board.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : status_sink
        int n;
        forever
        begin
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                n = 80;
            end
            else
                n = idle_len();
            if (n > 0)
            begin
                status_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            status_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        led_settings_t s;
        int            fault_pct;
        rst_n      <= 1'b0;
        tick_valid <= 1'b0;
        tick       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        send_ticks(TK_ALL_OK, 2);
        drain();

        s = uniform_settings('0);
        load_settings(s);
        send_ticks(TK_NET_DOWN, 10);
        send_ticks(TK_ALL_OK, 4);
        send_ticks(TK_UNPOWERED, 2);
        send_ticks(TK_SILENT, 2);
        drain();
        while (board.phase != PH_NET_SECOND)
        begin
            send_ticks(TK_NET_DOWN, 1);
            drain();
        end
        // The second pulse lasts gap plus on time, which here only fits in 17 bits.
        s.pulse_on  = 16'd1;
        s.pulse_gap = 16'hFFFF;
        load_settings(s);
        send_ticks(TK_NET_DOWN, 3);
        drain();

        s.override = 1'b1;
        s.level    = 1'b1;
        load_settings(s);
        send_ticks(TK_SILENT, 2);
        drain();
        s.level = 1'b0;
        load_settings(s);
        send_ticks(TK_ALL_OK, 2);
        drain();
        s.disabled = 1'b1;
        load_settings(s);
        send_ticks(TK_ALL_OK, 2);
        drain();

        s = uniform_settings(16'hFFFF);
        load_settings(s);
        send_ticks(TK_ALL_OK, 2);
        send_ticks(TK_UNPOWERED, 1);
        drain();

        send_ticks(TK_UNPOWERED, 2);
        send_ticks(TK_ALL_OK, 3);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            s.pulse_on    = rand_time();
            s.pulse_gap   = rand_time();
            s.group_pause = rand_time();
            s.rest_time   = rand_time();
            s.half_period = rand_time();
            s.disabled    = ($urandom_range(0, 9) == 0);
            s.override    = ($urandom_range(0, 6) == 0);
            s.level       = 1'($urandom_range(0, 1));
            load_settings(s);
            case ($urandom_range(0, 2))
                0:       fault_pct = 0;
                1:       fault_pct = 10;
                default: fault_pct = 60;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 1 || ph == 5)
                hold_armed = 1'b1;
            send_burst(45, fault_pct);
            drain();
        end

        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
sv/slbs_pkg.sv
sv/status_led_blink_sequencer.sv
bench/tb_status_led_blink_sequencer.sv
